// File: rtl/tpcc_pkg.sv
`default_nettype none

package tpcc_pkg;

	// Field widths of the command and result items.
	localparam int FUNC_W  = 3;
	localparam int TICK_W  = 17;
	localparam int TIME_W  = 20;
	localparam int STATE_W = 3;
	localparam int MIN_W   = 10;
	localparam int SEC_W   = 6;
	localparam int TENTH_W = 4;

	// Clock radices, in tenths of a second.
	localparam int MIN_LIMIT      = 1000;
	localparam int SEC_RADIX      = 60;
	localparam int TENTH_RADIX    = 10;
	localparam int TENTHS_PER_MIN = SEC_RADIX * TENTH_RADIX;

	// Time loaded after reset (thirty minutes) and the largest clock value.
	localparam logic [TIME_W-1:0] INIT_TIME_RESET = TIME_W'(30 * TENTHS_PER_MIN);
	localparam logic [TIME_W-1:0] MAX_TOTAL = TIME_W'(MIN_LIMIT * TENTHS_PER_MIN - 1);

	// Reciprocal constants for exact division by 600, 10 and 60 over the value ranges used.
	localparam int Q600_W   = 11;
	localparam int SHIFT600 = 30;
	localparam logic [20:0] RECIP600 = 21'd1789570;
	localparam int DIV10_W  = 16;
	localparam int SHIFT10  = 23;
	localparam logic [19:0] RECIP10 = 20'd838861;
	localparam int SHIFT60  = 22;
	localparam logic [16:0] RECIP60 = 17'd69906;

	// Command codes.
	localparam logic [FUNC_W-1:0] FUNC_RESET    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_START    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PAUSE    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CONTINUE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_SWITCH   = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_ADVANCE  = 3'd5;

	// Game states.
	typedef enum logic [STATE_W-1:0] {
		ST_INITIAL      = 3'd0,
		ST_STARTABLE    = 3'd1,
		ST_WHITE_PAUSED = 3'd2,
		ST_BLACK_PAUSED = 3'd3,
		ST_WHITE_MOVES  = 3'd4,
		ST_BLACK_MOVES  = 3'd5,
		ST_WHITE_WINS   = 3'd6,
		ST_BLACK_WINS   = 3'd7
	} game_state_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [TICK_W-1:0] tick_count;
	} cmd_item_t;

	typedef struct packed {
		logic [STATE_W-1:0] game_state;
		logic               accepted;
		logic [MIN_W-1:0]   black_minutes;
		logic [SEC_W-1:0]   black_seconds;
		logic [TENTH_W-1:0] black_tenths;
		logic [MIN_W-1:0]   white_minutes;
		logic [SEC_W-1:0]   white_seconds;
		logic [TENTH_W-1:0] white_tenths;
	} res_item_t;

	// Per-item status that travels alongside the clock conversion.
	typedef struct packed {
		logic [STATE_W-1:0] game_state;
		logic               accepted;
	} meta_t;

	// Load enables of the conversion stages.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} conv_ctl_t;

endpackage

`default_nettype wire

// File: rtl/tpcc_cfg.sv
`default_nettype none

module tpcc_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [tpcc_pkg::TIME_W-1:0]   cfg_data,
	output logic                               busy,
	output logic      [tpcc_pkg::TIME_W-1:0]   load_total
);

	logic [2*tpcc_pkg::TIME_W:0]   prod600;
	logic [tpcc_pkg::TIME_W-1:0]   time_s1;
	logic [tpcc_pkg::Q600_W-1:0]   minutes_s1;
	logic                          valid_s1;
	logic [tpcc_pkg::Q600_W-1:0]   excess;
	logic [tpcc_pkg::TIME_W-1:0]   excess_tenths;
	logic [tpcc_pkg::TIME_W-1:0]   load_total_q;

	// Whole minutes of the written time, by reciprocal multiplication.
	assign prod600 = (2 * tpcc_pkg::TIME_W + 1)'(cfg_data)
		* (2 * tpcc_pkg::TIME_W + 1)'(tpcc_pkg::RECIP600);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cfg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_valid) begin
			time_s1    <= cfg_data;
			minutes_s1 <= prod600[tpcc_pkg::SHIFT600 + tpcc_pkg::Q600_W - 1:tpcc_pkg::SHIFT600];
		end
	end

	// Minutes at or above the limit are clamped to the limit less one; seconds and tenths are kept.
	assign excess = minutes_s1 - tpcc_pkg::Q600_W'(tpcc_pkg::MIN_LIMIT - 1);
	assign excess_tenths = tpcc_pkg::TIME_W'(excess) * tpcc_pkg::TIME_W'(tpcc_pkg::TENTHS_PER_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_total_q <= tpcc_pkg::INIT_TIME_RESET;
		end else if (valid_s1) begin
			if (minutes_s1 >= tpcc_pkg::Q600_W'(tpcc_pkg::MIN_LIMIT)) begin
				load_total_q <= time_s1 - excess_tenths;
			end else begin
				load_total_q <= time_s1;
			end
		end
	end

	assign busy       = valid_s1;
	assign load_total = load_total_q;

endmodule

`default_nettype wire

// File: rtl/tpcc_core.sv
`default_nettype none

module tpcc_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_accept,
	input  wire tpcc_pkg::cmd_item_t          cmd,
	input  wire logic [tpcc_pkg::TIME_W-1:0]  load_total,
	output tpcc_pkg::meta_t                   meta,
	output logic      [tpcc_pkg::TIME_W-1:0]  white_total,
	output logic      [tpcc_pkg::TIME_W-1:0]  black_total
);

	tpcc_pkg::game_state_t          state_q, state_d;
	logic                           accepted_q, accepted_d;
	logic [tpcc_pkg::TIME_W-1:0]    white_q, white_d;
	logic [tpcc_pkg::TIME_W-1:0]    black_q, black_d;
	logic [tpcc_pkg::TIME_W-1:0]    ticks;
	logic [tpcc_pkg::TIME_W-1:0]    white_left, black_left;

	assign ticks = tpcc_pkg::TIME_W'(cmd.tick_count);

	// Saturating subtraction of the ticks from each clock.
	assign white_left = (ticks >= white_q) ? '0 : white_q - ticks;
	assign black_left = (ticks >= black_q) ? '0 : black_q - ticks;

	// Command decode against the current game state.
	always_comb begin
		state_d    = state_q;
		accepted_d = 1'b0;
		white_d    = white_q;
		black_d    = black_q;
		unique case (cmd.func)
			tpcc_pkg::FUNC_RESET: begin
				if (state_q == tpcc_pkg::ST_INITIAL || state_q == tpcc_pkg::ST_WHITE_PAUSED ||
					state_q == tpcc_pkg::ST_BLACK_PAUSED || state_q == tpcc_pkg::ST_WHITE_WINS ||
					state_q == tpcc_pkg::ST_BLACK_WINS) begin
					white_d    = load_total;
					black_d    = load_total;
					state_d    = tpcc_pkg::ST_STARTABLE;
					accepted_d = 1'b1;
				end
			end
			tpcc_pkg::FUNC_START: begin
				if (state_q == tpcc_pkg::ST_STARTABLE) begin
					state_d    = tpcc_pkg::ST_WHITE_MOVES;
					accepted_d = 1'b1;
				end
			end
			tpcc_pkg::FUNC_PAUSE: begin
				if (state_q == tpcc_pkg::ST_WHITE_MOVES) begin
					state_d    = tpcc_pkg::ST_WHITE_PAUSED;
					accepted_d = 1'b1;
				end else if (state_q == tpcc_pkg::ST_BLACK_MOVES) begin
					state_d    = tpcc_pkg::ST_BLACK_PAUSED;
					accepted_d = 1'b1;
				end
			end
			tpcc_pkg::FUNC_CONTINUE: begin
				if (state_q == tpcc_pkg::ST_WHITE_PAUSED) begin
					state_d    = tpcc_pkg::ST_WHITE_MOVES;
					accepted_d = 1'b1;
				end else if (state_q == tpcc_pkg::ST_BLACK_PAUSED) begin
					state_d    = tpcc_pkg::ST_BLACK_MOVES;
					accepted_d = 1'b1;
				end
			end
			tpcc_pkg::FUNC_SWITCH: begin
				if (state_q == tpcc_pkg::ST_WHITE_MOVES) begin
					state_d    = tpcc_pkg::ST_BLACK_MOVES;
					accepted_d = 1'b1;
				end else if (state_q == tpcc_pkg::ST_BLACK_MOVES) begin
					state_d    = tpcc_pkg::ST_WHITE_MOVES;
					accepted_d = 1'b1;
				end
			end
			tpcc_pkg::FUNC_ADVANCE: begin
				if (state_q == tpcc_pkg::ST_WHITE_MOVES) begin
					white_d    = white_left;
					accepted_d = 1'b1;
					if (white_left == '0) begin
						state_d = tpcc_pkg::ST_BLACK_WINS;
					end
				end else if (state_q == tpcc_pkg::ST_BLACK_MOVES) begin
					black_d    = black_left;
					accepted_d = 1'b1;
					if (black_left == '0) begin
						state_d = tpcc_pkg::ST_WHITE_WINS;
					end
				end
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	// Game state and both clocks; they also form the first stage of the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tpcc_pkg::ST_INITIAL;
			accepted_q <= 1'b0;
			white_q    <= '0;
			black_q    <= '0;
		end else if (cmd_accept) begin
			state_q    <= state_d;
			accepted_q <= accepted_d;
			white_q    <= white_d;
			black_q    <= black_d;
		end
	end

	assign meta.game_state = state_q;
	assign meta.accepted   = accepted_q;
	assign white_total     = white_q;
	assign black_total     = black_q;

	// Clocks never exceed the largest displayable time.
	a_white_range: assert property (@(posedge clk) disable iff (!arst_n)
		white_q <= tpcc_pkg::MAX_TOTAL) else $error("white clock out of range");
	a_black_range: assert property (@(posedge clk) disable iff (!arst_n)
		black_q <= tpcc_pkg::MAX_TOTAL) else $error("black clock out of range");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_accept |=> $stable(state_q) && $stable(white_q) && $stable(black_q))
		else $error("game state changed without an item");

endmodule

`default_nettype wire

// File: rtl/tpcc_conv.sv
`default_nettype none

module tpcc_conv (
	input  wire logic                          clk,
	input  wire tpcc_pkg::conv_ctl_t           ctl,
	input  wire logic [tpcc_pkg::TIME_W-1:0]   total,
	output logic      [tpcc_pkg::MIN_W-1:0]    minutes,
	output logic      [tpcc_pkg::SEC_W-1:0]    seconds,
	output logic      [tpcc_pkg::TENTH_W-1:0]  tenths
);

	logic [2*tpcc_pkg::TIME_W-1:0]   prod10;
	logic [tpcc_pkg::TIME_W-1:0]     total_s2;
	logic [tpcc_pkg::DIV10_W-1:0]    secs_s2;
	logic [tpcc_pkg::TIME_W-1:0]     back10;
	logic [32:0]                     prod60;
	logic [tpcc_pkg::DIV10_W-1:0]    secs_s3;
	logic [tpcc_pkg::MIN_W-1:0]      minutes_s3;
	logic [tpcc_pkg::TENTH_W-1:0]    tenths_s3;
	logic [tpcc_pkg::DIV10_W-1:0]    back60;
	logic [tpcc_pkg::MIN_W-1:0]      minutes_s4;
	logic [tpcc_pkg::SEC_W-1:0]      seconds_s4;
	logic [tpcc_pkg::TENTH_W-1:0]    tenths_s4;

	// Stage two: whole seconds of the total.
	assign prod10 = (2 * tpcc_pkg::TIME_W)'(total) * (2 * tpcc_pkg::TIME_W)'(tpcc_pkg::RECIP10);

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			total_s2 <= total;
			secs_s2  <= prod10[tpcc_pkg::SHIFT10 + tpcc_pkg::DIV10_W - 1:tpcc_pkg::SHIFT10];
		end
	end

	// Stage three: tenths left over, and whole minutes of the seconds.
	assign back10 = tpcc_pkg::TIME_W'(secs_s2) * tpcc_pkg::TIME_W'(tpcc_pkg::TENTH_RADIX);
	assign prod60 = 33'(secs_s2) * 33'(tpcc_pkg::RECIP60);

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			tenths_s3  <= tpcc_pkg::TENTH_W'(total_s2 - back10);
			secs_s3    <= secs_s2;
			minutes_s3 <= prod60[tpcc_pkg::SHIFT60 + tpcc_pkg::MIN_W - 1:tpcc_pkg::SHIFT60];
		end
	end

	// Stage four: seconds left over; these registers drive the result.
	assign back60 = tpcc_pkg::DIV10_W'(minutes_s3) * tpcc_pkg::DIV10_W'(tpcc_pkg::SEC_RADIX);

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			minutes_s4 <= minutes_s3;
			seconds_s4 <= tpcc_pkg::SEC_W'(secs_s3 - back60);
			tenths_s4  <= tenths_s3;
		end
	end

	assign minutes = minutes_s4;
	assign seconds = seconds_s4;
	assign tenths  = tenths_s4;

endmodule

`default_nettype wire

// File: rtl/two_player_chess_clock_unit.sv
`default_nettype none

// Chess clock for two players.
// Commands arrive on the cmd channel (valid/ready); each item gives exactly one
// result item on the res channel (valid/ready): game state, accept flag and both
// clocks as minutes, seconds and tenths.
// The initial time is written on the cfg channel, in tenths of a second. After a
// write, cmd_ready is low in the next cycle while the clamped load value is
// formed. Throughput is one item per cycle when nothing stalls. The game state
// and both clocks are updated when an item is accepted; the result passes stages
// two to four, with two reciprocal-multiply divisions (by ten, then by sixty).
// Every stage has its own valid bit, so a stalled receiver holds only the result
// register and items keep entering until the pipeline is full; then cmd_ready
// falls. Reset clears the game to its initial state with both clocks at zero and
// the initial time at thirty minutes; no result is pending after reset.
module two_player_chess_clock_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	output logic                              cmd_ready,
	input  wire tpcc_pkg::cmd_item_t          cmd,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output tpcc_pkg::res_item_t               res,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [tpcc_pkg::TIME_W-1:0]  cfg_data
);

	logic                           cfg_busy;
	logic [tpcc_pkg::TIME_W-1:0]    load_total;
	logic                           cmd_accept;
	tpcc_pkg::meta_t                meta_s1, meta_s2, meta_s3, meta_s4;
	logic [tpcc_pkg::TIME_W-1:0]    white_total, black_total;
	logic                           valid_s1, valid_s2, valid_s3, valid_s4;
	logic                           ready_s1, ready_s2, ready_s3, ready_s4;
	tpcc_pkg::conv_ctl_t            ctl;

	// Configuration path.
	tpcc_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.busy       (cfg_busy),
		.load_total (load_total)
	);

	assign cfg_ready = 1'b1;

	// Stage readiness: a stage moves on when it is empty or the next one moves.
	assign ready_s4   = !valid_s4 || res_ready;
	assign ready_s3   = !valid_s3 || ready_s4;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign cmd_ready  = ready_s1 && !cfg_busy;
	assign cmd_accept = cmd_valid && cmd_ready;

	assign ctl.ld_s2 = ready_s2;
	assign ctl.ld_s3 = ready_s3;
	assign ctl.ld_s4 = ready_s4;

	// Game state and clock update.
	tpcc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_accept  (cmd_accept),
		.cmd         (cmd),
		.load_total  (load_total),
		.meta        (meta_s1),
		.white_total (white_total),
		.black_total (black_total)
	);

	// Valid bits of the result pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= cmd_accept;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Game state and accept flag follow the clock conversion.
	always_ff @(posedge clk) begin
		if (ready_s2) begin
			meta_s2 <= meta_s1;
		end
		if (ready_s3) begin
			meta_s3 <= meta_s2;
		end
		if (ready_s4) begin
			meta_s4 <= meta_s3;
		end
	end

	// Conversion of each clock to minutes, seconds and tenths.
	tpcc_conv u_conv_black (
		.clk     (clk),
		.ctl     (ctl),
		.total   (black_total),
		.minutes (res.black_minutes),
		.seconds (res.black_seconds),
		.tenths  (res.black_tenths)
	);

	tpcc_conv u_conv_white (
		.clk     (clk),
		.ctl     (ctl),
		.total   (white_total),
		.minutes (res.white_minutes),
		.seconds (res.white_seconds),
		.tenths  (res.white_tenths)
	);

	assign res.game_state = meta_s4.game_state;
	assign res.accepted   = meta_s4.accepted;
	assign res_valid      = valid_s4;

	// A configuration write holds off commands for the following cycle.
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> !cmd_ready) else $error("item accepted while load value pending");
	// Result digits stay within their radices.
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.white_seconds < 6'd60 && res.black_seconds < 6'd60 &&
			res.white_tenths < 4'd10 && res.black_tenths < 4'd10 &&
			res.white_minutes < 10'd1000 && res.black_minutes < 10'd1000)
		else $error("result digit out of range");
	// An accepted item always lands in the first stage.
	a_stage1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_accept |=> valid_s1) else $error("accepted item lost");
	// A full pipeline with a stalled receiver accepts nothing.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && !res_ready) |-> !cmd_ready)
		else $error("item accepted into a full pipeline");

endmodule

`default_nettype wire
